FILE: rtl/vsf_pkg.sv
// ----------------------------------------------------------------------------
// vsf_pkg
// Shared types and constants of the voice session controller: beat layouts,
// state and event codes, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
package vsf_pkg;

  localparam int unsigned LIMIT_W   = 20;
  localparam int unsigned DELAY_W   = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 20;
  localparam int unsigned OUT_CNT_W = 32;

  typedef logic [LIMIT_W-1:0]   limit_t;
  typedef logic [DELAY_W-1:0]   delay_t;
  typedef logic [OUT_CNT_W-1:0] out_cnt_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_CONN   = 3'd1,
    ST_LISTEN = 3'd2,
    ST_SPEAK  = 3'd3,
    ST_ERROR  = 3'd4
  } sess_state_t;

  typedef enum logic [3:0] {
    ACT_TICK       = 4'd0,
    ACT_HELLO      = 4'd1,
    ACT_WAKEWORD   = 4'd2,
    ACT_CONN_OK    = 4'd3,
    ACT_CONN_FAIL  = 4'd4,
    ACT_SPEECH_GO  = 4'd5,
    ACT_SPEECH_END = 4'd6,
    ACT_STOP_LISTN = 4'd7,
    ACT_LINK_CLOSE = 4'd8,
    ACT_ERROR      = 4'd9,
    ACT_RESET      = 4'd10
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VALIDATE_EN = 3'd0,
    CFG_TIMEOUT_EN  = 3'd1,
    CFG_CONN_LIMIT  = 3'd2,
    CFG_LISTN_LIMIT = 3'd3,
    CFG_SPEAK_LIMIT = 3'd4,
    CFG_RET_DELAY   = 3'd5
  } cfg_index_t;

  typedef enum logic [1:0] {
    REQ_NONE   = 2'd0,
    REQ_ACCEPT = 2'd1,
    REQ_REJECT = 2'd2
  } req_res_t;

  localparam limit_t RST_CONN_LIMIT  = 20'd10000;
  localparam limit_t RST_LISTN_LIMIT = 20'd30000;
  localparam limit_t RST_SPEAK_LIMIT = 20'd60000;
  localparam delay_t RST_RET_DELAY   = 16'd500;

  typedef struct packed {
    logic [3:0] action;
    delay_t     ret_ms;
    logic       use_default_delay;
  } in_beat_t;

  typedef struct packed {
    logic [2:0] state_now;
    logic [2:0] state_before;
    logic       changed;
    logic       audio_on;
    logic       audio_toggled;
    logic       rejected;
    logic       timed_out;
    out_cnt_t   transitions_seen;
    out_cnt_t   rejections_seen;
    out_cnt_t   timeouts_seen;
    out_cnt_t   failures_seen;
  } out_beat_t;

endpackage

FILE: rtl/voice_session_fsm_with_timeouts_top.sv
// ----------------------------------------------------------------------------
// voice_session_fsm_with_timeouts_top
// Five-state voice session controller with per-state timeouts, a cancellable
// return-to-listening countdown and saturating event counters.
//
//   port group  dir  handshake          payload
//   in_*        in   in_valid/in_stall  vsf_pkg::in_beat_t
//   out_*       out  out_valid/out_stall vsf_pkg::out_beat_t
//   cfg_*       in   cfg_we             cfg_index, cfg_data
//
// one beat per cycle sustained while out_stall is low
// the input register feeds one pass of state logic into the result register
// rst_n is synchronous; state, counters, valid flags and configuration registers take their reset values
// out_stall holds the result register and, once the input register is full,
// raises in_stall in the same cycle
// ----------------------------------------------------------------------------
module voice_session_fsm_with_timeouts_top #(
  parameter int unsigned COUNT_WIDTH = 32,
  parameter int unsigned TIMER_WIDTH = 21
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  vsf_pkg::in_beat_t               in_beat,
  output logic                            out_valid,
  input  logic                            out_stall,
  output vsf_pkg::out_beat_t              out_beat,
  input  logic                            cfg_we,
  input  logic [vsf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [vsf_pkg::CFG_DAT_W-1:0]   cfg_data
);

  localparam int unsigned CmpW = (TIMER_WIDTH > vsf_pkg::LIMIT_W) ?
                                 TIMER_WIDTH : vsf_pkg::LIMIT_W;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;
  typedef logic [TIMER_WIDTH-1:0] tmr_t;

  // configuration
  logic            validate_en_r;
  logic            timeout_en_r;
  vsf_pkg::limit_t conn_limit_r;
  vsf_pkg::limit_t listn_limit_r;
  vsf_pkg::limit_t speak_limit_r;
  vsf_pkg::delay_t ret_delay_r;

  // handshake
  logic               s1_vld_r;
  vsf_pkg::in_beat_t  s1_beat_r;
  logic               out_vld_r;
  vsf_pkg::out_beat_t out_beat_r;
  vsf_pkg::out_beat_t out_beat_nxt;
  logic               adv;

  // session state
  vsf_pkg::sess_state_t state_r, state_nxt;
  logic                 audio_r, audio_nxt;
  tmr_t                 dwell_r, dwell_nxt;
  logic                 armed_r, armed_nxt;
  vsf_pkg::delay_t      cdown_r, cdown_nxt;
  cnt_t                 trans_cnt_r, trans_cnt_nxt;
  cnt_t                 rej_cnt_r, rej_cnt_nxt;
  cnt_t                 tmo_cnt_r, tmo_cnt_nxt;
  cnt_t                 fail_cnt_r, fail_cnt_nxt;

  function automatic logic is_legal(vsf_pkg::sess_state_t from,
                                    vsf_pkg::sess_state_t to);
    logic ok;
    unique case (from)
      vsf_pkg::ST_IDLE:   ok = (to == vsf_pkg::ST_CONN) || (to == vsf_pkg::ST_ERROR);
      vsf_pkg::ST_CONN:   ok = (to == vsf_pkg::ST_LISTEN) || (to == vsf_pkg::ST_IDLE) ||
                               (to == vsf_pkg::ST_ERROR);
      vsf_pkg::ST_LISTEN,
      vsf_pkg::ST_SPEAK:  ok = (to != vsf_pkg::ST_CONN);
      default:            ok = 1'b1;
    endcase
    return ok;
  endfunction

  function automatic vsf_pkg::req_res_t check_req(vsf_pkg::sess_state_t from,
                                                  vsf_pkg::sess_state_t to,
                                                  logic validate);
    vsf_pkg::req_res_t res;
    if (to == from) begin
      res = vsf_pkg::REQ_NONE;
    end else if (validate && !is_legal(from, to)) begin
      res = vsf_pkg::REQ_REJECT;
    end else begin
      res = vsf_pkg::REQ_ACCEPT;
    end
    return res;
  endfunction

  function automatic cnt_t sat_add(cnt_t c, logic [1:0] inc);
    logic [COUNT_WIDTH:0] sum;
    sum = {1'b0, c} + (COUNT_WIDTH+1)'(inc);
    return sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
  endfunction

  // handshake control
  assign adv       = s1_vld_r && (!out_vld_r || !out_stall);
  assign in_stall  = s1_vld_r && !adv;
  assign out_valid = out_vld_r;
  assign out_beat  = out_beat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= (in_valid && !in_stall) || (s1_vld_r && !adv);
      out_vld_r <= adv || (out_vld_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_beat_r <= in_beat;
    end
    if (adv) begin
      out_beat_r <= out_beat_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      validate_en_r <= 1'b1;
      timeout_en_r  <= 1'b1;
      conn_limit_r  <= vsf_pkg::RST_CONN_LIMIT;
      listn_limit_r <= vsf_pkg::RST_LISTN_LIMIT;
      speak_limit_r <= vsf_pkg::RST_SPEAK_LIMIT;
      ret_delay_r   <= vsf_pkg::RST_RET_DELAY;
    end else if (cfg_we) begin
      case (cfg_index)
        vsf_pkg::CFG_VALIDATE_EN: validate_en_r <= cfg_data[0];
        vsf_pkg::CFG_TIMEOUT_EN:  timeout_en_r  <= cfg_data[0];
        vsf_pkg::CFG_CONN_LIMIT:  conn_limit_r  <= cfg_data;
        vsf_pkg::CFG_LISTN_LIMIT: listn_limit_r <= cfg_data;
        vsf_pkg::CFG_SPEAK_LIMIT: speak_limit_r <= cfg_data;
        vsf_pkg::CFG_RET_DELAY:   ret_delay_r   <= cfg_data[vsf_pkg::DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  // session state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vsf_pkg::ST_IDLE;
      audio_r     <= 1'b0;
      dwell_r     <= '0;
      armed_r     <= 1'b0;
      cdown_r     <= '0;
      trans_cnt_r <= '0;
      rej_cnt_r   <= '0;
      tmo_cnt_r   <= '0;
      fail_cnt_r  <= '0;
    end else if (adv) begin
      state_r     <= state_nxt;
      audio_r     <= audio_nxt;
      dwell_r     <= dwell_nxt;
      armed_r     <= armed_nxt;
      cdown_r     <= cdown_nxt;
      trans_cnt_r <= trans_cnt_nxt;
      rej_cnt_r   <= rej_cnt_nxt;
      tmo_cnt_r   <= tmo_cnt_nxt;
      fail_cnt_r  <= fail_cnt_nxt;
    end
  end

  // next state and result
  always_comb begin
    logic                 req1_en;
    vsf_pkg::sess_state_t req1_tgt;
    vsf_pkg::req_res_t    res1;
    vsf_pkg::req_res_t    res2;
    logic                 is_tick;
    logic                 force_mute;
    logic                 tmo;
    logic                 fail;
    logic                 active;
    vsf_pkg::limit_t      limit;
    logic [1:0]           acc_n;
    logic [1:0]           rej_n;

    req1_en    = 1'b0;
    req1_tgt   = vsf_pkg::ST_IDLE;
    is_tick    = 1'b0;
    force_mute = 1'b0;
    fail       = 1'b0;
    tmo        = 1'b0;
    acc_n      = 2'd0;
    rej_n      = 2'd0;
    res2       = vsf_pkg::REQ_NONE;
    state_nxt  = state_r;
    audio_nxt  = audio_r;
    dwell_nxt  = dwell_r;
    armed_nxt  = armed_r;
    cdown_nxt  = cdown_r;

    unique case (s1_beat_r.action)
      vsf_pkg::ACT_TICK: begin
        is_tick = 1'b1;
        if (dwell_r != '1) begin
          dwell_nxt = dwell_r + tmr_t'(1);
        end
        if (armed_r) begin
          if (cdown_r <= vsf_pkg::delay_t'(1)) begin
            armed_nxt = 1'b0;
            cdown_nxt = '0;
            req1_en   = 1'b1;
            req1_tgt  = vsf_pkg::ST_LISTEN;
          end else begin
            cdown_nxt = cdown_r - vsf_pkg::delay_t'(1);
          end
        end
      end
      vsf_pkg::ACT_HELLO: begin
        req1_en    = 1'b1;
        req1_tgt   = vsf_pkg::ST_IDLE;
        force_mute = 1'b1;
      end
      vsf_pkg::ACT_WAKEWORD: begin
        req1_en  = 1'b1;
        req1_tgt = vsf_pkg::ST_CONN;
      end
      vsf_pkg::ACT_CONN_OK: begin
        req1_en  = 1'b1;
        req1_tgt = vsf_pkg::ST_LISTEN;
      end
      vsf_pkg::ACT_CONN_FAIL: begin
        fail     = 1'b1;
        req1_en  = 1'b1;
        req1_tgt = vsf_pkg::ST_IDLE;
      end
      vsf_pkg::ACT_SPEECH_GO: begin
        req1_en  = 1'b1;
        req1_tgt = vsf_pkg::ST_SPEAK;
      end
      vsf_pkg::ACT_SPEECH_END: begin
        armed_nxt = 1'b1;
        cdown_nxt = s1_beat_r.use_default_delay ? ret_delay_r : s1_beat_r.ret_ms;
      end
      vsf_pkg::ACT_STOP_LISTN,
      vsf_pkg::ACT_RESET: begin
        armed_nxt = 1'b0;
        req1_en   = 1'b1;
        req1_tgt  = vsf_pkg::ST_IDLE;
      end
      vsf_pkg::ACT_LINK_CLOSE: begin
        armed_nxt = 1'b0;
        req1_en   = (state_r == vsf_pkg::ST_CONN) || (state_r == vsf_pkg::ST_LISTEN) ||
                    (state_r == vsf_pkg::ST_SPEAK);
        req1_tgt  = vsf_pkg::ST_IDLE;
      end
      vsf_pkg::ACT_ERROR: begin
        armed_nxt = 1'b0;
        req1_en   = 1'b1;
        req1_tgt  = vsf_pkg::ST_ERROR;
      end
      default: ;
    endcase

    // first request: event or expired return countdown
    res1 = req1_en ? check_req(state_r, req1_tgt, validate_en_r) : vsf_pkg::REQ_NONE;
    if (res1 == vsf_pkg::REQ_ACCEPT) begin
      state_nxt = req1_tgt;
      dwell_nxt = '0;
      audio_nxt = (req1_tgt == vsf_pkg::ST_LISTEN);
      acc_n     = acc_n + 2'd1;
    end else if (res1 == vsf_pkg::REQ_REJECT) begin
      rej_n = rej_n + 2'd1;
    end

    // dwell timeout, checked on every tick while timeouts are enabled
    unique case (state_nxt)
      vsf_pkg::ST_CONN: begin
        active = 1'b1;
        limit  = conn_limit_r;
      end
      vsf_pkg::ST_LISTEN: begin
        active = 1'b1;
        limit  = listn_limit_r;
      end
      vsf_pkg::ST_SPEAK: begin
        active = 1'b1;
        limit  = speak_limit_r;
      end
      default: begin
        active = 1'b0;
        limit  = '0;
      end
    endcase
    if (is_tick && timeout_en_r && active && (CmpW'(dwell_nxt) > CmpW'(limit))) begin
      tmo  = 1'b1;
      res2 = check_req(state_nxt, vsf_pkg::ST_ERROR, validate_en_r);
    end
    if (res2 == vsf_pkg::REQ_ACCEPT) begin
      state_nxt = vsf_pkg::ST_ERROR;
      dwell_nxt = '0;
      audio_nxt = 1'b0;
      acc_n     = acc_n + 2'd1;
    end else if (res2 == vsf_pkg::REQ_REJECT) begin
      rej_n = rej_n + 2'd1;
    end

    if (force_mute) begin
      audio_nxt = 1'b0;
    end

    trans_cnt_nxt = sat_add(trans_cnt_r, acc_n);
    rej_cnt_nxt   = sat_add(rej_cnt_r, rej_n);
    tmo_cnt_nxt   = sat_add(tmo_cnt_r, {1'b0, tmo});
    fail_cnt_nxt  = sat_add(fail_cnt_r, {1'b0, fail});

    out_beat_nxt.state_now        = state_nxt;
    out_beat_nxt.state_before     = state_r;
    out_beat_nxt.changed          = (state_nxt != state_r);
    out_beat_nxt.audio_on         = audio_nxt;
    out_beat_nxt.audio_toggled    = (audio_nxt != audio_r);
    out_beat_nxt.rejected         = (rej_n != 2'd0);
    out_beat_nxt.timed_out        = tmo;
    out_beat_nxt.transitions_seen = vsf_pkg::out_cnt_t'(trans_cnt_nxt);
    out_beat_nxt.rejections_seen  = vsf_pkg::out_cnt_t'(rej_cnt_nxt);
    out_beat_nxt.timeouts_seen    = vsf_pkg::out_cnt_t'(tmo_cnt_nxt);
    out_beat_nxt.failures_seen    = vsf_pkg::out_cnt_t'(fail_cnt_nxt);
  end

  // audio upload tracks the listening state
  a_audio_listen: assert property (@(posedge clk) disable iff (!rst_n)
    audio_r == (state_r == vsf_pkg::ST_LISTEN))
    else $error("audio enable out of step with session state");

  // stall toward the source only with a held input beat
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_vld_r)
    else $error("input stalled with empty input register");

  // session state only moves when a beat is processed
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(adv) |-> $stable(state_r) && $stable(trans_cnt_r))
    else $error("session state changed without a beat");

  // counters never run backwards
  a_cnt_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (trans_cnt_r >= $past(trans_cnt_r)) &&
                     (rej_cnt_r >= $past(rej_cnt_r)) &&
                     (tmo_cnt_r >= $past(tmo_cnt_r)) &&
                     (fail_cnt_r >= $past(fail_cnt_r)))
    else $error("event counter decreased");

  // a processed beat lands in the result register
  a_adv_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_vld_r)
    else $error("processed beat missing from result register");

endmodule
